// ===== hw/rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the column smoother
// Weights, level formats, sequencer states and the control bundle that the
// sequencer hands to the arithmetic datapath.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int LEVEL_BITS    = 16;
  localparam int WEIGHT_BITS   = 17;
  localparam int SMOOTH_BITS   = 17;
  localparam int ROWS_CFG_BITS = 11;
  localparam int ROW_OUT_BITS  = 10;
  localparam int MUL_OP_BITS   = 18;
  localparam int PROD_BITS     = 2 * MUL_OP_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;
  localparam int OUT_DATA_BITS = 32;

  // Q1.16 filter weights, rounded to nearest
  localparam logic [WEIGHT_BITS-1:0] W_EDGE_SELF  = 17'd45875;
  localparam logic [WEIGHT_BITS-1:0] W_EDGE_NEIGH = 17'd19661;
  localparam logic [WEIGHT_BITS-1:0] W_SIDE       = 17'd13107;
  localparam logic [WEIGHT_BITS-1:0] W_MID        = 17'd39322;
  localparam logic [WEIGHT_BITS-1:0] W_UNITY      = 17'd65536;

  localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET   = 11'd1024;
  localparam logic [SMOOTH_BITS-1:0]   SMOOTH_RESET = 17'd32768;
  localparam logic [LEVEL_BITS-1:0]    FLOOR_RESET  = 16'h8800;  // -120.0 dB

  // tap slots of the 3-tap filter
  localparam logic [1:0] TAP_PREV   = 2'd0;
  localparam logic [1:0] TAP_CENTER = 2'd1;
  localparam logic [1:0] TAP_NEW    = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROWS   = 2'd0,
    REG_SMOOTH = 2'd1,
    REG_FLOOR  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_UPDATE
  } state_t;

  // which weight set a result uses
  typedef enum logic [1:0] {
    FK_PASS,
    FK_TOP,
    FK_MID,
    FK_BOT
  } kind_t;

  typedef struct packed {
    logic                   acc_clr;
    logic                   acc_add;
    logic                   mul_sel_int;
    logic                   diff_en;
    logic [LEVEL_BITS-1:0]  tap_sample;
    logic [WEIGHT_BITS-1:0] tap_weight;
  } dp_ctl_t;

  function automatic logic [WEIGHT_BITS-1:0] tap_weight(input kind_t kind,
                                                        input logic [1:0] idx);
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    unique case (kind)
      FK_PASS: w = (idx == TAP_NEW) ? W_UNITY : '0;
      FK_TOP: begin
        if (idx == TAP_CENTER) w = W_EDGE_SELF;
        else if (idx == TAP_NEW) w = W_EDGE_NEIGH;
      end
      FK_MID: w = (idx == TAP_CENTER) ? W_MID : W_SIDE;
      FK_BOT: begin
        if (idx == TAP_PREV) w = W_EDGE_NEIGH;
        else if (idx == TAP_CENTER) w = W_EDGE_SELF;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/scs_ram.sv =====
// ----------------------------------------------------------------------------
// scs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/scs_datapath.sv =====
// ----------------------------------------------------------------------------
// scs_datapath: shared multiplier, accumulator and band update
// One 18x18 multiplier serves both the filter taps and the integrator gain.
// ----------------------------------------------------------------------------
module scs_datapath
  import scs_pkg::*;
(
  input  logic                          clk,
  input  dp_ctl_t                       dp_ctl,
  input  logic [SMOOTH_BITS-1:0]        smoothing,
  input  logic signed [LEVEL_BITS-1:0]  band_rd,
  output logic signed [LEVEL_BITS-1:0]  new_band
);

  localparam int DIFF_BITS  = LEVEL_BITS + 1;
  localparam int DELTA_BITS = PROD_BITS - 16;
  localparam int SUM_BITS   = DELTA_BITS + 1;

  logic signed [MUL_OP_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0]   mult_r;
  logic signed [PROD_BITS-1:0]   acc_r, acc_nxt;
  logic signed [PROD_BITS-1:0]   acc_rnd, prod_rnd;
  logic signed [LEVEL_BITS-1:0]  fval;
  logic signed [LEVEL_BITS-1:0]  band_r;
  logic signed [DIFF_BITS-1:0]   diff_r;
  logic signed [DELTA_BITS-1:0]  delta;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    lvl_max, lvl_min;

  // operand select: filter tap or integrator gain
  always_comb begin
    if (dp_ctl.mul_sel_int) begin
      mul_a = MUL_OP_BITS'(diff_r);
      mul_b = $signed(MUL_OP_BITS'(smoothing));
    end else begin
      mul_a = MUL_OP_BITS'($signed(dp_ctl.tap_sample));
      mul_b = $signed(MUL_OP_BITS'(dp_ctl.tap_weight));
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (dp_ctl.acc_clr) acc_nxt = '0;
    else if (dp_ctl.acc_add) acc_nxt = acc_r + mult_r;
  end

  always_ff @(posedge clk) begin
    mult_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
  end

  // round Q8.24 to Q8.8, halves toward +inf
  assign acc_rnd = acc_r + PROD_BITS'(32768);
  assign fval    = acc_rnd[LEVEL_BITS+15:16];

  always_ff @(posedge clk) begin
    if (dp_ctl.diff_en) begin
      band_r <= band_rd;
      diff_r <= DIFF_BITS'(fval) - DIFF_BITS'(band_rd);
    end
  end

  assign prod_rnd = mult_r + PROD_BITS'(32768);
  assign delta    = prod_rnd[PROD_BITS-1:16];
  assign sum      = SUM_BITS'(band_r) + SUM_BITS'(delta);
  assign lvl_max  = SUM_BITS'({1'b0, {(LEVEL_BITS-1){1'b1}}});
  assign lvl_min  = -lvl_max - SUM_BITS'(1);

  always_comb begin
    if (sum > lvl_max) new_band = LEVEL_BITS'(lvl_max);
    else if (sum < lvl_min) new_band = LEVEL_BITS'(lvl_min);
    else new_band = LEVEL_BITS'(sum);
  end

endmodule

// ===== hw/rtl/scs_ctrl.sv =====
// ----------------------------------------------------------------------------
// scs_ctrl: row sequencer for the column smoother
// Tracks the row position and tap samples, steps the shared datapath through
// each result, runs the band clearing sweep and holds the output register.
// ----------------------------------------------------------------------------
module scs_ctrl
  import scs_pkg::*;
#(
  parameter int MAX_ROWS = 1024
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic                                         in_tuser,
  input  logic [LEVEL_BITS-1:0]                        in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [OUT_DATA_BITS-1:0]                     out_tdata,
  output logic                                         out_tlast,
  input  logic [ROWS_CFG_BITS-1:0]                     rows_in_use,
  input  logic [LEVEL_BITS-1:0]                        floor_level,
  input  logic signed [LEVEL_BITS-1:0]                 new_band,
  output dp_ctl_t                                      dp_ctl,
  output logic                                         ram_we,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ram_waddr,
  output logic [LEVEL_BITS-1:0]                        ram_wdata,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ram_raddr
);

  localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_BITS = ($clog2(MAX_ROWS + 1) > ROWS_CFG_BITS) ?
                            $clog2(MAX_ROWS + 1) : ROWS_CFG_BITS;
  localparam logic [CNT_BITS-1:0] MAX_CNT  = CNT_BITS'(MAX_ROWS);
  localparam logic [RW-1:0]       LAST_ROW = RW'(MAX_ROWS - 1);
  localparam int OUT_PAD = OUT_DATA_BITS - ROW_OUT_BITS - LEVEL_BITS;

  state_t state_r, state_nxt;
  kind_t  kind_r;
  logic [1:0]            cnt_r;
  logic [RW-1:0]         row_pos_r, p_r, emit_row_r, clr_cnt_r;
  logic                  second_r, done_r;
  logic [LEVEL_BITS-1:0] prev_r, center_r, s_r, fill_r;
  logic                  out_valid_r, out_done_r;
  logic [ROW_OUT_BITS-1:0] out_row_r;
  logic [LEVEL_BITS-1:0] out_band_r;

  logic [CNT_BITS-1:0] rows_ext, rows_eff, rows_m1, pos_ext, p_ext;
  logic [RW-1:0]       p_cur, p_inc, p_dec;
  logic                is_last, is_short, p_zero, p_one;
  logic                accept, out_free, load_out;
  logic [31:0]         row_wide;

  // effective row count and wrapped row position
  always_comb begin
    rows_ext = CNT_BITS'(rows_in_use);
    if (rows_ext == '0) rows_eff = CNT_BITS'(1);
    else if (rows_ext > MAX_CNT) rows_eff = MAX_CNT;
    else rows_eff = rows_ext;
    rows_m1  = rows_eff - CNT_BITS'(1);
    pos_ext  = CNT_BITS'(row_pos_r);
    p_cur    = (pos_ext >= rows_eff) ? '0 : row_pos_r;
    p_ext    = CNT_BITS'(p_cur);
    p_inc    = p_cur + RW'(1);
    p_dec    = p_cur - RW'(1);
    is_last  = (p_ext == rows_m1);
    is_short = (rows_eff <= CNT_BITS'(2));
    p_zero   = (p_cur == '0);
    p_one    = (p_ext == CNT_BITS'(1));
  end

  assign accept   = in_tvalid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign load_out = (state_r == ST_UPDATE) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == LAST_ROW) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser) state_nxt = ST_CLEAR;
          else if (is_short || !p_zero) state_nxt = ST_MAC;
        end
      end
      ST_MAC:    if (cnt_r == TAP_NEW) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = second_r ? ST_MAC : ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready          = (state_r == ST_IDLE);
    dp_ctl.acc_clr     = (state_r == ST_MAC) && (cnt_r == TAP_PREV);
    dp_ctl.acc_add     = ((state_r == ST_MAC) && (cnt_r != TAP_PREV)) ||
                         (state_r == ST_READ);
    // keep the gain product steady while the update step waits on the output
    dp_ctl.mul_sel_int = (state_r == ST_MUL) || (state_r == ST_UPDATE);
    dp_ctl.diff_en     = (state_r == ST_DIFF);
    dp_ctl.tap_weight  = tap_weight(kind_r, cnt_r);
    unique case (cnt_r)
      TAP_PREV:   dp_ctl.tap_sample = prev_r;
      TAP_CENTER: dp_ctl.tap_sample = center_r;
      default:    dp_ctl.tap_sample = s_r;
    endcase
    ram_we    = (state_r == ST_CLEAR) || load_out;
    ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : emit_row_r;
    ram_wdata = (state_r == ST_CLEAR) ? fill_r : new_band;
    ram_raddr = emit_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      fill_r    <= FLOOR_RESET;
      row_pos_r <= '0;
      prev_r    <= '0;
      center_r  <= '0;
      cnt_r     <= '0;
      second_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= (clr_cnt_r == LAST_ROW) ? '0 : clr_cnt_r + RW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_tuser) begin
              // latch the floor now: config may change during the sweep
              fill_r    <= floor_level;
              row_pos_r <= '0;
              clr_cnt_r <= '0;
            end else begin
              s_r   <= in_tdata;
              cnt_r <= TAP_PREV;
              if (is_short) begin
                kind_r     <= FK_PASS;
                emit_row_r <= p_cur;
                done_r     <= is_last;
                second_r   <= 1'b0;
                row_pos_r  <= is_last ? '0 : p_inc;
              end else if (p_zero) begin
                center_r  <= in_tdata;
                row_pos_r <= p_inc;
              end else begin
                kind_r     <= p_one ? FK_TOP : FK_MID;
                emit_row_r <= p_dec;
                done_r     <= 1'b0;
                second_r   <= is_last;
                p_r        <= p_cur;
                row_pos_r  <= is_last ? '0 : p_inc;
              end
            end
          end
        end
        ST_MAC: begin
          if (cnt_r == TAP_NEW) begin
            cnt_r <= TAP_PREV;
            // advance the tap window once the interior or top row is summed
            if (kind_r == FK_TOP || kind_r == FK_MID) begin
              prev_r   <= center_r;
              center_r <= s_r;
            end
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end
        ST_UPDATE: begin
          if (out_free && second_r) begin
            second_r   <= 1'b0;
            kind_r     <= FK_BOT;
            emit_row_r <= p_r;
            done_r     <= 1'b1;
            cnt_r      <= TAP_PREV;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  assign row_wide = 32'(emit_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row_r  <= row_wide[ROW_OUT_BITS-1:0];
      out_band_r <= new_band;
      out_done_r <= done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_band_r, out_row_r};
  assign out_tlast  = out_done_r;

endmodule

// ===== hw/rtl/spectrogram_column_smoother.sv =====
// ----------------------------------------------------------------------------
// spectrogram_column_smoother: vertical 3-tap smoother with per-row bands
// Filters one spectrogram column row by row and runs a leaky integrator per
// row, kept in a band RAM.
//
//   port group  dir  content
//   in_*        in   word: tuser = opcode, tdata = sample_level (Q8.8)
//   out_*       out  word: tdata = row_index, band_level; tlast = column_done
//   cfg_*       in   register write: rows_in_use, smoothing_factor, floor_level
//
// A sample that yields no result is only accepted; a sample with one result
// steps the shared multiplier through accept, 3 taps, read, diff, gain and
// update, and the last row of a column yields two results in turn. A clear
// word sweeps the band RAM. After reset a sweep of the band RAM runs before
// in_tready rises. A stalled output holds the sequencer in its update step.
// ----------------------------------------------------------------------------
module spectrogram_column_smoother
  import scs_pkg::*;
#(
  parameter int MAX_ROWS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [LEVEL_BITS-1:0]    in_tdata,   // [15:0] sample_level
  input  logic                     in_tuser,   // [0] opcode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [9:0] row_index, [25:10] band_level
  output logic                     out_tlast,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ROWS_CFG_BITS-1:0] rows_in_use_r;
  logic [SMOOTH_BITS-1:0]   smoothing_r;
  logic [LEVEL_BITS-1:0]    floor_level_r;

  dp_ctl_t                      dp_ctl;
  logic signed [LEVEL_BITS-1:0] new_band;
  logic                         ram_we;
  logic [RW-1:0]                ram_waddr, ram_raddr;
  logic [LEVEL_BITS-1:0]        ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
      smoothing_r   <= SMOOTH_RESET;
      floor_level_r <= FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS:   rows_in_use_r <= cfg_wdata[ROWS_CFG_BITS-1:0];
        REG_SMOOTH: smoothing_r   <= cfg_wdata[SMOOTH_BITS-1:0];
        REG_FLOOR:  floor_level_r <= cfg_wdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  scs_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .rows_in_use (rows_in_use_r),
    .floor_level (floor_level_r),
    .new_band    (new_band),
    .dp_ctl      (dp_ctl),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr)
  );

  scs_datapath u_datapath (
    .clk       (clk),
    .dp_ctl    (dp_ctl),
    .smoothing (smoothing_r),
    .band_rd   ($signed(ram_rdata)),
    .new_band  (new_band)
  );

  scs_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (MAX_ROWS)
  ) u_band_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
